// ===== design/rv64dec_pkg.sv =====
// RV64IM decoder package: opcode and funct7 constants, format and operation codes,
// and the opcode/funct decode function.
// No dependencies.
package rv64dec_pkg;

    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_OPIMMW = 7'b0011011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_OPW    = 7'b0111011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [6:0] F7_MEXT = 7'b0000001;

    localparam logic [11:0] SYS_ECALL  = 12'b000000000000;
    localparam logic [11:0] SYS_EBREAK = 12'b000000000001;

    typedef enum logic [2:0] {
        FMT_R = 3'd0,
        FMT_I = 3'd1,
        FMT_S = 3'd2,
        FMT_B = 3'd3,
        FMT_U = 3'd4,
        FMT_J = 3'd5
    } fmt_t;

    typedef enum logic [6:0] {
        OP_ILLEGAL = 7'd0,
        OP_ADD     = 7'd1,  OP_SUB    = 7'd2,  OP_MUL    = 7'd3,  OP_SLL    = 7'd4,
        OP_MULH    = 7'd5,  OP_SLT    = 7'd6,  OP_MULHSU = 7'd7,  OP_SLTU   = 7'd8,
        OP_MULHU   = 7'd9,  OP_XOR    = 7'd10, OP_DIV    = 7'd11, OP_SRL    = 7'd12,
        OP_SRA     = 7'd13, OP_DIVU   = 7'd14, OP_OR     = 7'd15, OP_REM    = 7'd16,
        OP_AND     = 7'd17, OP_REMU   = 7'd18,
        OP_ADDW    = 7'd19, OP_SUBW   = 7'd20, OP_MULW   = 7'd21, OP_SLLW   = 7'd22,
        OP_DIVW    = 7'd23, OP_SRLW   = 7'd24, OP_SRAW   = 7'd25, OP_DIVUW  = 7'd26,
        OP_REMW    = 7'd27, OP_REMUW  = 7'd28,
        OP_LB      = 7'd29, OP_LH     = 7'd30, OP_LW     = 7'd31, OP_LD     = 7'd32,
        OP_LBU     = 7'd33, OP_LHU    = 7'd34, OP_LWU    = 7'd35,
        OP_ADDI    = 7'd36, OP_SLLI   = 7'd37, OP_SLTI   = 7'd38, OP_SLTIU  = 7'd39,
        OP_XORI    = 7'd40, OP_SRLI   = 7'd41, OP_SRAI   = 7'd42, OP_ORI    = 7'd43,
        OP_ANDI    = 7'd44, OP_JALR   = 7'd45,
        OP_ECALL   = 7'd46, OP_EBREAK = 7'd47, OP_CSRRW  = 7'd48, OP_CSRRS  = 7'd49,
        OP_CSRRC   = 7'd50, OP_CSRRWI = 7'd51, OP_CSRRSI = 7'd52, OP_CSRRCI = 7'd53,
        OP_ADDIW   = 7'd54, OP_SLLIW  = 7'd55, OP_SRLIW  = 7'd56, OP_SRAIW  = 7'd57,
        OP_SB      = 7'd58, OP_SH     = 7'd59, OP_SW     = 7'd60, OP_SD     = 7'd61,
        OP_BEQ     = 7'd62, OP_BNE    = 7'd63, OP_BLT    = 7'd64, OP_BGE    = 7'd65,
        OP_BLTU    = 7'd66, OP_BGEU   = 7'd67,
        OP_AUIPC   = 7'd68, OP_LUI    = 7'd69, OP_JAL    = 7'd70
    } op_t;

    typedef struct packed {
        fmt_t fmt;
        op_t  op;
    } dec_t;

    function automatic dec_t decode_word(input logic [31:0] word);
        logic [2:0]  f3;
        logic [6:0]  f7;
        dec_t        res;
        f3 = word[14:12];
        f7 = word[31:25];
        res.fmt = FMT_R;
        res.op  = OP_ILLEGAL;
        unique case (word[6:0])
            OPC_OP: begin
                res.fmt = FMT_R;
                if (f7 == F7_BASE) begin
                    unique case (f3)
                        3'd0: res.op = OP_ADD;
                        3'd1: res.op = OP_SLL;
                        3'd2: res.op = OP_SLT;
                        3'd3: res.op = OP_SLTU;
                        3'd4: res.op = OP_XOR;
                        3'd5: res.op = OP_SRL;
                        3'd6: res.op = OP_OR;
                        default: res.op = OP_AND;
                    endcase
                end else if (f7 == F7_ALT) begin
                    unique case (f3)
                        3'd0: res.op = OP_SUB;
                        3'd5: res.op = OP_SRA;
                        default: res.op = OP_ILLEGAL;
                    endcase
                end else if (f7 == F7_MEXT) begin
                    unique case (f3)
                        3'd0: res.op = OP_MUL;
                        3'd1: res.op = OP_MULH;
                        3'd2: res.op = OP_MULHSU;
                        3'd3: res.op = OP_MULHU;
                        3'd4: res.op = OP_DIV;
                        3'd5: res.op = OP_DIVU;
                        3'd6: res.op = OP_REM;
                        default: res.op = OP_REMU;
                    endcase
                end
            end
            OPC_OPW: begin
                res.fmt = FMT_R;
                unique case (f3)
                    3'd0: begin
                        if (f7 == F7_BASE)      res.op = OP_ADDW;
                        else if (f7 == F7_ALT)  res.op = OP_SUBW;
                        else if (f7 == F7_MEXT) res.op = OP_MULW;
                    end
                    3'd1: res.op = OP_SLLW;
                    3'd4: res.op = OP_DIVW;
                    3'd5: begin
                        if (f7 == F7_BASE)      res.op = OP_SRLW;
                        else if (f7 == F7_ALT)  res.op = OP_SRAW;
                        else if (f7 == F7_MEXT) res.op = OP_DIVUW;
                    end
                    3'd6: res.op = OP_REMW;
                    3'd7: res.op = OP_REMUW;
                    default: res.op = OP_ILLEGAL;
                endcase
            end
            OPC_LOAD: begin
                res.fmt = FMT_I;
                unique case (f3)
                    3'd0: res.op = OP_LB;
                    3'd1: res.op = OP_LH;
                    3'd2: res.op = OP_LW;
                    3'd3: res.op = OP_LD;
                    3'd4: res.op = OP_LBU;
                    3'd5: res.op = OP_LHU;
                    3'd6: res.op = OP_LWU;
                    default: res.op = OP_ILLEGAL;
                endcase
            end
            OPC_OPIMM: begin
                res.fmt = FMT_I;
                unique case (f3)
                    3'd0: res.op = OP_ADDI;
                    3'd1: res.op = OP_SLLI;
                    3'd2: res.op = OP_SLTI;
                    3'd3: res.op = OP_SLTIU;
                    3'd4: res.op = OP_XORI;
                    3'd5: begin
                        if (f7 == F7_BASE)     res.op = OP_SRLI;
                        else if (f7 == F7_ALT) res.op = OP_SRAI;
                    end
                    3'd6: res.op = OP_ORI;
                    default: res.op = OP_ANDI;
                endcase
            end
            OPC_JALR: begin
                res.fmt = FMT_I;
                if (f3 == 3'd0) res.op = OP_JALR;
            end
            OPC_SYSTEM: begin
                res.fmt = FMT_I;
                unique case (f3)
                    3'd0: begin
                        if (word[31:20] == SYS_ECALL)       res.op = OP_ECALL;
                        else if (word[31:20] == SYS_EBREAK) res.op = OP_EBREAK;
                    end
                    3'd1: res.op = OP_CSRRW;
                    3'd2: res.op = OP_CSRRS;
                    3'd3: res.op = OP_CSRRC;
                    3'd5: res.op = OP_CSRRWI;
                    3'd6: res.op = OP_CSRRSI;
                    3'd7: res.op = OP_CSRRCI;
                    default: res.op = OP_ILLEGAL;
                endcase
            end
            OPC_OPIMMW: begin
                res.fmt = FMT_I;
                unique case (f3)
                    3'd0: res.op = OP_ADDIW;
                    3'd1: res.op = OP_SLLIW;
                    3'd5: begin
                        if (f7 == F7_BASE)     res.op = OP_SRLIW;
                        else if (f7 == F7_ALT) res.op = OP_SRAIW;
                    end
                    default: res.op = OP_ILLEGAL;
                endcase
            end
            OPC_STORE: begin
                res.fmt = FMT_S;
                unique case (f3)
                    3'd0: res.op = OP_SB;
                    3'd1: res.op = OP_SH;
                    3'd2: res.op = OP_SW;
                    3'd3: res.op = OP_SD;
                    default: res.op = OP_ILLEGAL;
                endcase
            end
            OPC_BRANCH: begin
                res.fmt = FMT_B;
                unique case (f3)
                    3'd0: res.op = OP_BEQ;
                    3'd1: res.op = OP_BNE;
                    3'd4: res.op = OP_BLT;
                    3'd5: res.op = OP_BGE;
                    3'd6: res.op = OP_BLTU;
                    3'd7: res.op = OP_BGEU;
                    default: res.op = OP_ILLEGAL;
                endcase
            end
            OPC_AUIPC: begin
                res.fmt = FMT_U;
                res.op  = OP_AUIPC;
            end
            OPC_LUI: begin
                res.fmt = FMT_U;
                res.op  = OP_LUI;
            end
            OPC_JAL: begin
                res.fmt = FMT_J;
                res.op  = OP_JAL;
            end
            default: begin
                res.fmt = FMT_R;
                res.op  = OP_ILLEGAL;
            end
        endcase
        return res;
    endfunction

endpackage

// ===== design/rv64im_instruction_decoder_top.sv =====
// RV64IM instruction decoder, top level: input register, field decode, result register.
// Depends on rv64dec_pkg.
//
// Usage:
//   Input channel s_valid/s_ready carries one 32-bit instruction word per item
//   (s_instr_word). Result channel m_valid/m_ready carries the decoded item:
//   legal flag, format, operation code, register fields, funct3/funct7,
//   sign-extended immediate, shift amount and CSR address.
//   An accepted word is held in the input register, decoded, and then loaded
//   into the result register, which drives m_valid and the result fields.
//   Throughput is one item per cycle while m_ready stays high;
//   the decode between the two registers is a single shallow pass of opcode,
//   funct3, funct7 and word[31:20] compares plus immediate bit selection.
//   When the receiver holds m_ready low, the result register holds its item,
//   the input register keeps its item, and s_ready drops once both are full;
//   up to two items are buffered. Both stages move again as soon as m_ready
//   returns high.
//   Reset (aresetn low, synchronous) empties both stages; s_ready is high in
//   the first cycle after reset. Illegal words still produce an item with
//   m_legal low and m_op_code zero.
module rv64im_instruction_decoder_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [31:0]               s_instr_word,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_legal,
    output rv64dec_pkg::fmt_t         m_format,
    output rv64dec_pkg::op_t          m_op_code,
    output logic [4:0]                m_dest_reg,
    output logic [4:0]                m_src1_reg,
    output logic [4:0]                m_src2_reg,
    output logic [2:0]                m_funct3_field,
    output logic [6:0]                m_funct7_field,
    output logic signed [31:0]        m_immediate,
    output logic [4:0]                m_shift_amount,
    output logic [11:0]               m_csr_addr
);
    import rv64dec_pkg::*;

    logic               in_valid_reg;
    logic [31:0]        instr_reg;
    logic               out_valid_reg;
    logic               out_adv;
    logic               in_adv;
    dec_t               dec;
    logic signed [31:0] imm_next;
    logic               legal_reg;
    fmt_t               format_reg;
    op_t                op_reg;
    logic signed [31:0] imm_reg;
    logic [31:0]        word_reg;

    assign out_adv = !out_valid_reg || m_ready;
    assign in_adv  = !in_valid_reg || out_adv;
    assign s_ready = in_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_adv) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv && s_valid) begin
            instr_reg <= s_instr_word;
        end
    end

    always_comb begin
        dec = decode_word(instr_reg);
        unique case (dec.fmt)
            FMT_I: imm_next = {{20{instr_reg[31]}}, instr_reg[31:20]};
            FMT_S: imm_next = {{20{instr_reg[31]}}, instr_reg[31:25], instr_reg[11:7]};
            FMT_B: imm_next = {{19{instr_reg[31]}}, instr_reg[31], instr_reg[7],
                               instr_reg[30:25], instr_reg[11:8], 1'b0};
            FMT_U: imm_next = {instr_reg[31:12], 12'b0};
            FMT_J: imm_next = {{11{instr_reg[31]}}, instr_reg[31], instr_reg[19:12],
                               instr_reg[20], instr_reg[30:21], 1'b0};
            default: imm_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && in_valid_reg) begin
            legal_reg  <= (dec.op != OP_ILLEGAL);
            format_reg <= dec.fmt;
            op_reg     <= dec.op;
            imm_reg    <= imm_next;
            word_reg   <= instr_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_legal        = legal_reg;
    assign m_format       = format_reg;
    assign m_op_code      = op_reg;
    assign m_dest_reg     = word_reg[11:7];
    assign m_src1_reg     = word_reg[19:15];
    assign m_src2_reg     = word_reg[24:20];
    assign m_funct3_field = word_reg[14:12];
    assign m_funct7_field = word_reg[31:25];
    assign m_immediate    = imm_reg;
    assign m_shift_amount = word_reg[24:20];
    assign m_csr_addr     = word_reg[31:20];

endmodule

// ===== design/rv64dec_checker.sv =====
// Port-level checker for the RV64IM decoder and its bind to the top level.
// Depends on rv64dec_pkg and rv64im_instruction_decoder_top.
module rv64dec_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_legal,
    input rv64dec_pkg::fmt_t         m_format,
    input rv64dec_pkg::op_t          m_op_code,
    input logic [4:0]                m_src2_reg,
    input logic [6:0]                m_funct7_field,
    input logic signed [31:0]        m_immediate,
    input logic [4:0]                m_shift_amount,
    input logic [11:0]               m_csr_addr
);
    import rv64dec_pkg::*;

    a_legal_op: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_legal == (m_op_code != OP_ILLEGAL)))
        else $error("legal flag disagrees with op code");

    a_r_imm_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_format == FMT_R) |-> (m_immediate == 32'sd0))
        else $error("R format item with nonzero immediate");

    a_fields_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_shift_amount == m_src2_reg && m_csr_addr[4:0] == m_src2_reg
                     && m_csr_addr[11:5] == m_funct7_field))
        else $error("slice fields disagree");

    a_u_low_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_format == FMT_U) |-> (m_immediate[11:0] == 12'd0))
        else $error("U format immediate low bits not zero");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_op_code) && $stable(m_immediate)))
        else $error("result item changed while stalled");

endmodule

bind rv64im_instruction_decoder_top rv64dec_checker u_rv64dec_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_legal        (m_legal),
    .m_format       (m_format),
    .m_op_code      (m_op_code),
    .m_src2_reg     (m_src2_reg),
    .m_funct7_field (m_funct7_field),
    .m_immediate    (m_immediate),
    .m_shift_amount (m_shift_amount),
    .m_csr_addr     (m_csr_addr)
);

// ===== tb/sv/tb_rv64im_instruction_decoder_top.sv =====
// Testbench for rv64im_instruction_decoder_top: directed table, then random words, all checked
// against typed-row values or a local decode predictor under random bursts and result stalls.
// Depends on rv64dec_pkg and the rv64im_instruction_decoder_top RTL.
`timescale 1ns / 100ps

module tb_rv64im_instruction_decoder_top;
    import rv64dec_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic        legal;
        fmt_t        fmt;
        op_t         op;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] imm;
        logic [4:0]  shamt;
        logic [11:0] csr;
    } decode_t;

    // typed == 1: legal/fmt/op/imm are given here, otherwise the predictor decides
    typedef struct packed {
        logic [31:0] word;
        logic        typed;
        logic        legal;
        fmt_t        fmt;
        op_t         op;
        logic [31:0] imm;
    } vector_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_CHOKED} rx_mode_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [31:0]       s_instr_word = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_legal;
    fmt_t              m_format;
    op_t               m_op_code;
    logic [4:0]        m_dest_reg;
    logic [4:0]        m_src1_reg;
    logic [4:0]        m_src2_reg;
    logic [2:0]        m_funct3_field;
    logic [6:0]        m_funct7_field;
    logic signed [31:0] m_immediate;
    logic [4:0]        m_shift_amount;
    logic [11:0]       m_csr_addr;

    decode_t  pending_decodes[$];
    vector_t  directed_vectors[$];
    decode_t  item_decode = '0;
    decode_t  want;
    decode_t  got;
    decode_t  row_decode;
    vector_t  row;
    bit       ops_seen[0:127];
    int       burst_left = 0;
    int       mismatch_count = 0;
    int       decoded_count = 0;
    int       legal_count = 0;
    int       ops_hit = 0;
    int       cycle_count = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    logic [7:0] rx_pattern = 8'b1001_0110;

    rv64im_instruction_decoder_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_instr_word   (s_instr_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_legal        (m_legal),
        .m_format       (m_format),
        .m_op_code      (m_op_code),
        .m_dest_reg     (m_dest_reg),
        .m_src1_reg     (m_src1_reg),
        .m_src2_reg     (m_src2_reg),
        .m_funct3_field (m_funct3_field),
        .m_funct7_field (m_funct7_field),
        .m_immediate    (m_immediate),
        .m_shift_amount (m_shift_amount),
        .m_csr_addr     (m_csr_addr)
    );

    always #5 aclk = ~aclk;

    function automatic decode_t slice_fields(input logic [31:0] w);
        decode_t d;
        d       = '0;
        d.fmt   = FMT_R;
        d.op    = OP_ILLEGAL;
        d.rd    = w[11:7];
        d.rs1   = w[19:15];
        d.rs2   = w[24:20];
        d.f3    = w[14:12];
        d.f7    = w[31:25];
        d.shamt = w[24:20];
        d.csr   = w[31:20];
        return d;
    endfunction

    function automatic decode_t predict_decode(input logic [31:0] w);
        decode_t    d;
        logic [2:0] f3;
        logic [6:0] f7;
        d  = slice_fields(w);
        f3 = w[14:12];
        f7 = w[31:25];
        case (w[6:0])
            OPC_OP: begin
                case ({f7, f3})
                    {F7_BASE, 3'd0}: d.op = OP_ADD;
                    {F7_BASE, 3'd1}: d.op = OP_SLL;
                    {F7_BASE, 3'd2}: d.op = OP_SLT;
                    {F7_BASE, 3'd3}: d.op = OP_SLTU;
                    {F7_BASE, 3'd4}: d.op = OP_XOR;
                    {F7_BASE, 3'd5}: d.op = OP_SRL;
                    {F7_BASE, 3'd6}: d.op = OP_OR;
                    {F7_BASE, 3'd7}: d.op = OP_AND;
                    {F7_ALT,  3'd0}: d.op = OP_SUB;
                    {F7_ALT,  3'd5}: d.op = OP_SRA;
                    {F7_MEXT, 3'd0}: d.op = OP_MUL;
                    {F7_MEXT, 3'd1}: d.op = OP_MULH;
                    {F7_MEXT, 3'd2}: d.op = OP_MULHSU;
                    {F7_MEXT, 3'd3}: d.op = OP_MULHU;
                    {F7_MEXT, 3'd4}: d.op = OP_DIV;
                    {F7_MEXT, 3'd5}: d.op = OP_DIVU;
                    {F7_MEXT, 3'd6}: d.op = OP_REM;
                    {F7_MEXT, 3'd7}: d.op = OP_REMU;
                    default:         d.op = OP_ILLEGAL;
                endcase
            end
            OPC_OPW: begin
                case (f3)
                    3'd1: d.op = OP_SLLW;
                    3'd4: d.op = OP_DIVW;
                    3'd6: d.op = OP_REMW;
                    3'd7: d.op = OP_REMUW;
                    3'd0, 3'd5: begin
                        case ({f7, f3})
                            {F7_BASE, 3'd0}: d.op = OP_ADDW;
                            {F7_ALT,  3'd0}: d.op = OP_SUBW;
                            {F7_MEXT, 3'd0}: d.op = OP_MULW;
                            {F7_BASE, 3'd5}: d.op = OP_SRLW;
                            {F7_ALT,  3'd5}: d.op = OP_SRAW;
                            {F7_MEXT, 3'd5}: d.op = OP_DIVUW;
                            default:         d.op = OP_ILLEGAL;
                        endcase
                    end
                    default: d.op = OP_ILLEGAL;
                endcase
            end
            OPC_LOAD: begin
                d.fmt = FMT_I;
                if (f3 != 3'd7) d.op = op_t'(OP_LB + f3);
            end
            OPC_OPIMM: begin
                d.fmt = FMT_I;
                if (f3 == 3'd5) begin
                    if (f7 == F7_BASE) d.op = OP_SRLI;
                    else if (f7 == F7_ALT) d.op = OP_SRAI;
                end else if (f3 < 3'd5) begin
                    d.op = op_t'(OP_ADDI + f3);
                end else begin
                    d.op = op_t'(OP_SRAI + f3 - 3'd5);
                end
            end
            OPC_JALR: begin
                d.fmt = FMT_I;
                if (f3 == 3'd0) d.op = OP_JALR;
            end
            OPC_SYSTEM: begin
                d.fmt = FMT_I;
                if (f3 == 3'd0) begin
                    if (w[31:20] == SYS_ECALL) d.op = OP_ECALL;
                    else if (w[31:20] == SYS_EBREAK) d.op = OP_EBREAK;
                end else if (f3 <= 3'd3) begin
                    d.op = op_t'(OP_EBREAK + f3);
                end else if (f3 != 3'd4) begin
                    d.op = op_t'(OP_ECALL + f3);
                end
            end
            OPC_OPIMMW: begin
                d.fmt = FMT_I;
                if (f3 == 3'd0) d.op = OP_ADDIW;
                else if (f3 == 3'd1) d.op = OP_SLLIW;
                else if (f3 == 3'd5 && f7 == F7_BASE) d.op = OP_SRLIW;
                else if (f3 == 3'd5 && f7 == F7_ALT) d.op = OP_SRAIW;
            end
            OPC_STORE: begin
                d.fmt = FMT_S;
                if (f3 < 3'd4) d.op = op_t'(OP_SB + f3);
            end
            OPC_BRANCH: begin
                d.fmt = FMT_B;
                if (f3 == 3'd0) d.op = OP_BEQ;
                else if (f3 == 3'd1) d.op = OP_BNE;
                else if (f3 >= 3'd4) d.op = op_t'(OP_BLT + f3 - 3'd4);
            end
            OPC_AUIPC: begin
                d.fmt = FMT_U;
                d.op  = OP_AUIPC;
            end
            OPC_LUI: begin
                d.fmt = FMT_U;
                d.op  = OP_LUI;
            end
            OPC_JAL: begin
                d.fmt = FMT_J;
                d.op  = OP_JAL;
            end
            default: begin
                d.fmt = FMT_R;
                d.op  = OP_ILLEGAL;
            end
        endcase
        case (d.fmt)
            FMT_I:   d.imm = {{20{w[31]}}, w[31:20]};
            FMT_S:   d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
            FMT_B:   d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            FMT_U:   d.imm = {w[31:12], 12'b0};
            FMT_J:   d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            default: d.imm = '0;
        endcase
        d.legal = (d.op != OP_ILLEGAL);
        return d;
    endfunction

    // mostly known opcodes with biased funct7, some raw noise
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        int          pick;
        w = $urandom;
        if ($urandom_range(0, 9) == 0) return w;
        case ($urandom_range(0, 11))
            0:       w[6:0] = OPC_LOAD;
            1:       w[6:0] = OPC_OPIMM;
            2:       w[6:0] = OPC_AUIPC;
            3:       w[6:0] = OPC_OPIMMW;
            4:       w[6:0] = OPC_STORE;
            5:       w[6:0] = OPC_OP;
            6:       w[6:0] = OPC_LUI;
            7:       w[6:0] = OPC_OPW;
            8:       w[6:0] = OPC_BRANCH;
            9:       w[6:0] = OPC_JALR;
            10:      w[6:0] = OPC_JAL;
            default: w[6:0] = OPC_SYSTEM;
        endcase
        pick = $urandom_range(0, 7);
        if (pick < 2) w[31:25] = F7_BASE;
        else if (pick < 4) w[31:25] = F7_ALT;
        else if (pick == 4) w[31:25] = F7_MEXT;
        if (w[6:0] == OPC_SYSTEM && w[14:12] == 3'd0 && $urandom_range(0, 2) != 0)
            w[31:20] = $urandom_range(0, 1) ? SYS_EBREAK : SYS_ECALL;
        return w;
    endfunction

    function automatic string show_decode(input decode_t d);
        return {$sformatf("legal=%0d fmt=%0d op=%0d rd=%0d rs1=%0d rs2=%0d ",
                          d.legal, d.fmt, d.op, d.rd, d.rs1, d.rs2),
                $sformatf("f3=%0d f7=%h imm=%h shamt=%0d csr=%h",
                          d.f3, d.f7, d.imm, d.shamt, d.csr)};
    endfunction

    function automatic void add_vector(input logic [31:0] w, input logic typed, input logic legal,
                                       input fmt_t fmt, input op_t op, input logic [31:0] imm);
        vector_t v;
        v.word  = w;
        v.typed = typed;
        v.legal = legal;
        v.fmt   = fmt;
        v.op    = op;
        v.imm   = imm;
        directed_vectors = {directed_vectors, v};
    endfunction

    // sender bursts: a random gap opens each new burst
    task automatic send_word(input logic [31:0] w, input decode_t d);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                       : $urandom_range(1, 10);
        end
        s_valid      <= 1'b1;
        s_instr_word <= w;
        item_decode  <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_pattern <= {rx_pattern[6:0], rx_pattern[7]};
        case (rx_mode)
            RX_OPEN:    m_ready <= 1'b1;
            RX_RANDOM:  m_ready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: m_ready <= rx_pattern[7];
            default:    m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) pending_decodes = {pending_decodes, item_decode};
            if (m_valid && m_ready) begin
                got.legal = m_legal;
                got.fmt   = m_format;
                got.op    = m_op_code;
                got.rd    = m_dest_reg;
                got.rs1   = m_src1_reg;
                got.rs2   = m_src2_reg;
                got.f3    = m_funct3_field;
                got.f7    = m_funct7_field;
                got.imm   = m_immediate;
                got.shamt = m_shift_amount;
                got.csr   = m_csr_addr;
                if (pending_decodes.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("ERROR: unexpected item %s", show_decode(got));
                    mismatch_count++;
                end else begin
                    want = pending_decodes.pop_front();
                    decoded_count++;
                    if (want.legal) legal_count++;
                    ops_seen[want.op] = 1'b1;
                    if (got !== want) begin
                        if (mismatch_count < 10) begin
                            $display("ERROR: item %0d mismatch", decoded_count);
                            $display("  expected %s", show_decode(want));
                            $display("  actual   %s", show_decode(got));
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d items outstanding",
                     cycle_count, pending_decodes.size());
            $display("rv64im_instruction_decoder_top verification failed");
            $finish;
        end
    end

    initial begin
        add_vector(32'h0000_0000, 1'b1, 1'b0, FMT_R, OP_ILLEGAL, 32'h0000_0000);
        add_vector(32'hFFFF_FFFF, 1'b1, 1'b0, FMT_R, OP_ILLEGAL, 32'h0000_0000);
        add_vector(32'h0000_0013, 1'b1, 1'b1, FMT_I, OP_ADDI,    32'h0000_0000);
        add_vector(32'hFFF0_0013, 1'b1, 1'b1, FMT_I, OP_ADDI,    32'hFFFF_FFFF);
        add_vector(32'h0000_0073, 1'b1, 1'b1, FMT_I, OP_ECALL,   32'h0000_0000);
        add_vector(32'h0010_0073, 1'b1, 1'b1, FMT_I, OP_EBREAK,  32'h0000_0001);
        add_vector(32'h0020_0073, 1'b1, 1'b0, FMT_I, OP_ILLEGAL, 32'h0000_0002);
        add_vector(32'h0000_4073, 1'b1, 1'b0, FMT_I, OP_ILLEGAL, 32'h0000_0000);
        add_vector(32'hFFFF_F037, 1'b1, 1'b1, FMT_U, OP_LUI,     32'hFFFF_F000);
        add_vector(32'h8000_0017, 1'b1, 1'b1, FMT_U, OP_AUIPC,   32'h8000_0000);
        add_vector(32'hFFFF_FFEF, 1'b1, 1'b1, FMT_J, OP_JAL,     32'hFFFF_FFFE);
        add_vector(32'h7FFF_F06F, 1'b1, 1'b1, FMT_J, OP_JAL,     32'h000F_FFFE);
        add_vector(32'hFE00_0FE3, 1'b1, 1'b1, FMT_B, OP_BEQ,     32'hFFFF_FFFE);
        add_vector(32'h0000_2063, 1'b1, 1'b0, FMT_B, OP_ILLEGAL, 32'h0000_0000);
        add_vector(32'hFE00_3FA3, 1'b1, 1'b1, FMT_S, OP_SD,      32'hFFFF_FFFF);
        add_vector(32'h0000_4023, 1'b1, 1'b0, FMT_S, OP_ILLEGAL, 32'h0000_0000);
        add_vector(32'h0000_7003, 1'b1, 1'b0, FMT_I, OP_ILLEGAL, 32'h0000_0000);
        add_vector(32'hFE00_0033, 1'b1, 1'b0, FMT_R, OP_ILLEGAL, 32'h0000_0000);
        add_vector(32'h0000_1067, 1'b1, 1'b0, FMT_I, OP_ILLEGAL, 32'h0000_0000);
        add_vector(32'h0200_5013, 1'b1, 1'b0, FMT_I, OP_ILLEGAL, 32'h0000_0020);
        // ecall with rd/rs1 set, funct7-blind shifts, csr immediate form
        add_vector(32'h000F_8FF3, 1'b0, 1'b0, FMT_R, OP_ILLEGAL, 32'h0);
        add_vector(32'hFE00_103B, 1'b0, 1'b0, FMT_R, OP_ILLEGAL, 32'h0);
        add_vector(32'hFFF0_1013, 1'b0, 1'b0, FMT_R, OP_ILLEGAL, 32'h0);
        add_vector(32'hFE00_101B, 1'b0, 1'b0, FMT_R, OP_ILLEGAL, 32'h0);
        add_vector(32'hFFFF_FFF3, 1'b0, 1'b0, FMT_R, OP_ILLEGAL, 32'h0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < directed_vectors.size(); i++) begin
            row = directed_vectors[i];
            if (row.typed) begin
                row_decode       = slice_fields(row.word);
                row_decode.legal = row.legal;
                row_decode.fmt   = row.fmt;
                row_decode.op    = row.op;
                row_decode.imm   = row.imm;
            end else begin
                row_decode = predict_decode(row.word);
            end
            send_word(row.word, row_decode);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            row.word = random_word();
            send_word(row.word, predict_decode(row.word));
        end
        s_valid <= 1'b0;

        while (pending_decodes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        for (int i = 1; i <= 70; i++) if (ops_seen[i]) ops_hit++;
        $display("Decoded %0d instruction words under random bursts and result stalls:",
                 decoded_count);
        $display("  %0d legal, %0d illegal, %0d of 70 operations reached, %0d mismatches",
                 legal_count, decoded_count - legal_count, ops_hit, mismatch_count);
        if (mismatch_count == 0) begin
            $display("rv64im_instruction_decoder_top verification clean");
        end else begin
            $display("rv64im_instruction_decoder_top verification failed");
        end
        $finish;
    end

endmodule
